@@ src/wav_pcm_stream_parser_unit_macros.svh @@
// Assertion helpers for the WAV stream parser.
`ifndef WAV_PCM_STREAM_PARSER_UNIT_MACROS_SVH
`define WAV_PCM_STREAM_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define WPS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define WPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/wps_pkg.sv @@
package wps_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;
	localparam logic [31:0] FMT_SIZE = 32'd16;
	localparam logic [15:0] FMT_PCM  = 16'd1;
	localparam logic [15:0] ONE_CHAN = 16'd1;
	localparam logic [31:0] RATE_RST = 32'd44100;

	typedef enum logic [2:0] {
		ERR_NONE  = 3'd0,
		ERR_RIFF  = 3'd1,
		ERR_WAVE  = 3'd2,
		ERR_PCM   = 3'd3,
		ERR_MONO  = 3'd4,
		ERR_RATE  = 3'd5,
		ERR_TRUNC = 3'd6
	} err_t;

	typedef enum logic [1:0] {
		ST_HEADER = 2'd0,
		ST_DATA   = 2'd1,
		ST_DONE   = 2'd2,
		ST_ERROR  = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [15:0] sample;
		status_t            status;
		err_t               error_code;
		logic               sample_valid;
	} result_t;

endpackage

@@ src/wav_pcm_stream_parser_unit.sv @@
// WAV/RIFF PCM parser: takes one file byte per transaction and returns one result per byte
// (sample_valid, sample, status, error_code). It checks RIFF/WAVE, skips chunks until the
// fmt chunk, which must be 16-byte mono PCM at the configured rate, then skips until data and
// turns byte pairs into signed 16-bit samples. A byte is accepted every cycle while the
// output side keeps up; each byte goes through the input register, the parse step and the
// result register. Errors hold until a byte with restart set.
`include "wav_pcm_stream_parser_unit_macros.svh"

module wav_pcm_stream_parser_unit
	import wps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic [0:0]  s_axis_tuser,   // [0] restart
	input  logic        s_axis_tlast,   // end_of_stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [15:0] sample, [17:16] status, [20:18] error_code
	output logic [0:0]  m_axis_tuser,   // [0] sample_valid
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	typedef enum logic [2:0] {
		PH_HEADER    = 3'd0,
		PH_FMT_SEEK  = 3'd1,
		PH_FMT_SKIP  = 3'd2,
		PH_FMT       = 3'd3,
		PH_DATA_SEEK = 3'd4,
		PH_DATA_SKIP = 3'd5,
		PH_DATA      = 3'd6,
		PH_DONE      = 3'd7
	} phase_t;

	logic [31:0] rate_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        restart_s1;
	logic        eos_s1;

	phase_t      phase_q,  phase_d;
	logic [4:0]  cnt_q,    cnt_d;
	logic [31:0] shift_q,  shift_d;
	logic [31:0] skip_q,   skip_d;
	logic [31:0] dleft_q,  dleft_d;
	logic [7:0]  low_q,    low_d;
	logic        lowp_q,   lowp_d;
	err_t        err_q,    err_d;

	logic        out_valid_q;
	result_t     res_q,    res_d;
	logic        advance;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_comb begin
		logic [31:0] skip_m1;
		logic [31:0] dleft_m1;
		phase_d = phase_q;
		cnt_d   = cnt_q;
		shift_d = shift_q;
		skip_d  = skip_q;
		dleft_d = dleft_q;
		low_d   = low_q;
		lowp_d  = lowp_q;
		err_d   = err_q;
		res_d.sample       = '0;
		res_d.sample_valid = 1'b0;
		if (restart_s1) begin
			phase_d = PH_HEADER;
			cnt_d   = '0;
			shift_d = '0;
			skip_d  = '0;
			dleft_d = '0;
			low_d   = '0;
			lowp_d  = 1'b0;
			err_d   = ERR_NONE;
		end
		skip_m1  = skip_d - 32'd1;
		dleft_m1 = dleft_d - 32'd1;
		if (err_d == ERR_NONE) begin
			shift_d = {byte_s1, shift_d[31:8]};
			case (phase_d)
				PH_HEADER: begin
					if (cnt_d == 5'd3 && shift_d != TAG_RIFF) begin
						err_d = ERR_RIFF;
					end else if (cnt_d == 5'd11 && shift_d != TAG_WAVE) begin
						err_d = ERR_WAVE;
					end
					if (cnt_d >= 5'd11) begin
						phase_d = PH_FMT_SEEK;
						cnt_d   = '0;
					end else begin
						cnt_d = cnt_d + 5'd1;
					end
				end
				PH_FMT_SEEK, PH_DATA_SEEK: begin
					if (cnt_d == 5'd3) begin
						if (phase_d == PH_FMT_SEEK && shift_d == TAG_FMT) begin
							phase_d = PH_FMT;
							cnt_d   = '0;
						end else if (phase_d == PH_DATA_SEEK && shift_d == TAG_DATA) begin
							cnt_d = 5'd8;
						end else begin
							cnt_d = 5'd4;
						end
					end else if (cnt_d == 5'd7) begin
						skip_d = shift_d;
						cnt_d  = '0;
						if (shift_d != '0) begin
							phase_d = (phase_d == PH_FMT_SEEK) ? PH_FMT_SKIP : PH_DATA_SKIP;
						end
					end else if (cnt_d == 5'd11) begin
						dleft_d = shift_d;
						cnt_d   = '0;
						lowp_d  = 1'b0;
						phase_d = (shift_d != '0) ? PH_DATA : PH_DONE;
					end else begin
						cnt_d = cnt_d + 5'd1;
					end
				end
				PH_FMT_SKIP, PH_DATA_SKIP: begin
					skip_d = skip_m1;
					if (skip_m1 == '0) begin
						phase_d = (phase_d == PH_FMT_SKIP) ? PH_FMT_SEEK : PH_DATA_SEEK;
						cnt_d   = '0;
					end
				end
				PH_FMT: begin
					if (cnt_d == 5'd3) begin
						skip_d = shift_d;
					end else if (cnt_d == 5'd5) begin
						if (shift_d[31:16] != FMT_PCM || skip_d != FMT_SIZE) begin
							err_d = ERR_PCM;
						end
					end else if (cnt_d == 5'd7) begin
						if (shift_d[31:16] != ONE_CHAN) begin
							err_d = ERR_MONO;
						end
					end else if (cnt_d == 5'd11) begin
						if (shift_d != rate_q) begin
							err_d = ERR_RATE;
						end
					end
					if (cnt_d >= 5'd19) begin
						phase_d = PH_DATA_SEEK;
						cnt_d   = '0;
						skip_d  = '0;
					end else begin
						cnt_d = cnt_d + 5'd1;
					end
				end
				PH_DATA: begin
					if (lowp_d) begin
						res_d.sample       = {byte_s1, low_d};
						res_d.sample_valid = 1'b1;
						lowp_d             = 1'b0;
					end else begin
						low_d  = byte_s1;
						lowp_d = 1'b1;
					end
					dleft_d = dleft_m1;
					if (dleft_m1 == '0) begin
						lowp_d  = 1'b0;
						phase_d = PH_DONE;
					end
				end
				default: begin
				end
			endcase
			if (eos_s1 && err_d == ERR_NONE && phase_d != PH_DONE) begin
				err_d = ERR_TRUNC;
			end
		end
		res_d.error_code = err_d;
		if (err_d != ERR_NONE) begin
			res_d.status = ST_ERROR;
		end else if (phase_d == PH_DATA) begin
			res_d.status = ST_DATA;
		end else if (phase_d == PH_DONE) begin
			res_d.status = ST_DONE;
		end else begin
			res_d.status = ST_HEADER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q      <= RATE_RST;
			valid_s1    <= 1'b0;
			restart_s1  <= 1'b0;
			eos_s1      <= 1'b0;
			phase_q     <= PH_HEADER;
			cnt_q       <= '0;
			shift_q     <= '0;
			skip_q      <= '0;
			dleft_q     <= '0;
			low_q       <= '0;
			lowp_q      <= 1'b0;
			err_q       <= ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				rate_q <= cfg_wdata;
			end
			if (s_axis_tready) begin
				valid_s1   <= s_axis_tvalid;
				restart_s1 <= s_axis_tuser[0];
				eos_s1     <= s_axis_tlast;
			end
			if (advance) begin
				phase_q <= phase_d;
				cnt_q   <= cnt_d;
				shift_q <= shift_d;
				skip_q  <= skip_d;
				dleft_q <= dleft_d;
				low_q   <= low_d;
				lowp_q  <= lowp_d;
				err_q   <= err_d;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, res_q.error_code, res_q.status, res_q.sample};
	assign m_axis_tuser  = res_q.sample_valid;

	`WPS_ASSERT_NOW(a_sample_no_err, m_axis_tvalid && res_q.sample_valid,
		res_q.error_code == ERR_NONE || res_q.error_code == ERR_TRUNC,
		"sample presented with a parse error")
	`WPS_ASSERT_NOW(a_status_err, m_axis_tvalid,
		(res_q.status == ST_ERROR) == (res_q.error_code != ERR_NONE),
		"status and error code disagree")
	`WPS_ASSERT_NEXT(a_err_hold, advance && !restart_s1 && err_q != ERR_NONE,
		err_q == $past(err_q) && !res_q.sample_valid,
		"held error changed without restart")

endmodule

@@ tb/tb_wav_pcm_stream_parser_unit.sv @@
module tb_wav_pcm_stream_parser_unit;
	import wps_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int PHASE_BYTES = 40;

	typedef enum logic [2:0] {
		P_HEADER, P_FMT_SEEK, P_FMT_SKIP, P_FMT, P_DATA_SEEK, P_DATA_SKIP, P_DATA, P_DONE
	} parse_phase_t;

	class wav_parse_tracker;
		parse_phase_t ph;
		logic [4:0]   fld_cnt;
		logic [31:0]  fld_shift;
		logic [31:0]  skip_left;
		logic [31:0]  data_left;
		logic [7:0]   low_byte;
		bit           low_held;
		err_t         err;
		logic [31:0]  want_rate;
		result_t      pending_results[$];
		int           byte_count;
		int           result_count;
		int           error_count;

		function new();
			want_rate = RATE_RST;
			byte_count = 0;
			result_count = 0;
			error_count = 0;
			restart_parse();
		endfunction

		function void restart_parse();
			ph = P_HEADER;
			fld_cnt = '0;
			fld_shift = '0;
			skip_left = '0;
			data_left = '0;
			low_byte = '0;
			low_held = 1'b0;
			err = ERR_NONE;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		// One byte in, one predicted result out.
		function void parse_byte(logic [7:0] b, logic rs, logic eo);
			result_t    r;
			logic [4:0] c;
			r = '0;
			byte_count++;
			if (rs)
				restart_parse();
			if (err == ERR_NONE) begin
				fld_shift = {b, fld_shift[31:8]};
				c = fld_cnt;
				case (ph)
					P_HEADER: begin
						if (c == 5'd3 && fld_shift != TAG_RIFF)
							err = ERR_RIFF;
						else if (c == 5'd11 && fld_shift != TAG_WAVE)
							err = ERR_WAVE;
						if (c >= 5'd11) begin
							ph = P_FMT_SEEK;
							fld_cnt = '0;
						end else
							fld_cnt = c + 5'd1;
					end
					P_FMT_SEEK, P_DATA_SEEK: begin
						if (c == 5'd3) begin
							if (ph == P_FMT_SEEK && fld_shift == TAG_FMT) begin
								ph = P_FMT;
								fld_cnt = '0;
							end else if (ph == P_DATA_SEEK && fld_shift == TAG_DATA)
								fld_cnt = 5'd8;
							else
								fld_cnt = 5'd4;
						end else if (c == 5'd7) begin
							skip_left = fld_shift;
							fld_cnt = '0;
							if (skip_left != 0) begin
								if (ph == P_FMT_SEEK)
									ph = P_FMT_SKIP;
								else
									ph = P_DATA_SKIP;
							end
						end else if (c == 5'd11) begin
							data_left = fld_shift;
							fld_cnt = '0;
							low_held = 1'b0;
							if (data_left != 0)
								ph = P_DATA;
							else
								ph = P_DONE;
						end else
							fld_cnt = c + 5'd1;
					end
					P_FMT_SKIP, P_DATA_SKIP: begin
						skip_left = skip_left - 32'd1;
						if (skip_left == 0) begin
							if (ph == P_FMT_SKIP)
								ph = P_FMT_SEEK;
							else
								ph = P_DATA_SEEK;
							fld_cnt = '0;
						end
					end
					P_FMT: begin
						if (c == 5'd3)
							skip_left = fld_shift;
						else if (c == 5'd5) begin
							if (fld_shift[31:16] != FMT_PCM || skip_left != FMT_SIZE)
								err = ERR_PCM;
						end else if (c == 5'd7) begin
							if (fld_shift[31:16] != ONE_CHAN)
								err = ERR_MONO;
						end else if (c == 5'd11) begin
							if (fld_shift != want_rate)
								err = ERR_RATE;
						end
						if (c >= 5'd19) begin
							ph = P_DATA_SEEK;
							fld_cnt = '0;
							skip_left = '0;
						end else
							fld_cnt = c + 5'd1;
					end
					P_DATA: begin
						if (low_held) begin
							r.sample = {b, low_byte};
							r.sample_valid = 1'b1;
							low_held = 1'b0;
						end else begin
							low_byte = b;
							low_held = 1'b1;
						end
						data_left = data_left - 32'd1;
						if (data_left == 0) begin
							low_held = 1'b0;
							ph = P_DONE;
						end
					end
					default: ;
				endcase
				if (eo && err == ERR_NONE && ph != P_DONE)
					err = ERR_TRUNC;
			end
			if (err != ERR_NONE)
				r.status = ST_ERROR;
			else if (ph == P_DATA)
				r.status = ST_DATA;
			else if (ph == P_DONE)
				r.status = ST_DONE;
			else
				r.status = ST_HEADER;
			r.error_code = err;
			pending_results.push_back(r);
		endfunction

		task report(string msg);
			error_count++;
			if (error_count <= 30)
				$display("mismatch: %s", msg);
		endtask

		task match_result(logic [23:0] data, logic valid);
			result_t exp_r;
			result_count++;
			if (pending_results.size() == 0) begin
				report($sformatf("result %0d arrived with none pending (%h)", result_count, data));
				return;
			end
			exp_r = pending_results.pop_front();
			if (valid !== exp_r.sample_valid)
				report($sformatf("result %0d sample_valid %b, want %b",
					result_count, valid, exp_r.sample_valid));
			if (data[15:0] !== exp_r.sample)
				report($sformatf("result %0d sample %h, want %h",
					result_count, data[15:0], exp_r.sample));
			if (data[17:16] !== exp_r.status)
				report($sformatf("result %0d status %0d, want %0d",
					result_count, data[17:16], exp_r.status));
			if (data[20:18] !== exp_r.error_code)
				report($sformatf("result %0d error_code %0d, want %0d",
					result_count, data[20:18], exp_r.error_code));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // [7:0] in_byte
	logic [0:0]  s_axis_tuser = '0;   // [0] restart
	logic        s_axis_tlast = 1'b0; // end_of_stream
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // [15:0] sample, [17:16] status, [20:18] error_code
	logic [0:0]  m_axis_tuser;        // [0] sample_valid
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;

	wav_parse_tracker tracker = new();
	logic [7:0]       wav_bytes[$];

	wav_pcm_stream_parser_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.match_result(m_axis_tdata, m_axis_tuser[0]);
	end

	function automatic void put8(logic [7:0] v);
		wav_bytes.push_back(v);
	endfunction

	function automatic void put16(logic [15:0] v);
		put8(v[7:0]);
		put8(v[15:8]);
	endfunction

	function automatic void put32(logic [31:0] v);
		put16(v[15:0]);
		put16(v[31:16]);
	endfunction

	function automatic void put_chunk(logic [31:0] tag);
		int n;
		n = $urandom_range(0, 6);
		put32(tag);
		put32(n);
		repeat (n) put8(8'($urandom));
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	// Mostly well-formed file, with occasional bad fields or a flipped bit.
	function automatic void make_wav(logic [31:0] rate);
		int n;
		wav_bytes.delete();
		put32(TAG_RIFF);
		put32($urandom);
		put32(TAG_WAVE);
		repeat ($urandom_range(0, 2))
			put_chunk(($urandom_range(0, 3) == 0) ? TAG_DATA : 32'($urandom));
		put32(TAG_FMT);
		put32(($urandom_range(0, 15) == 0) ? 32'($urandom_range(0, 40)) : FMT_SIZE);
		put16(($urandom_range(0, 15) == 0) ? 16'($urandom) : FMT_PCM);
		put16(($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 2)) : ONE_CHAN);
		put32(($urandom_range(0, 15) == 0) ? 32'($urandom) : rate);
		repeat (8) put8(8'($urandom));
		repeat ($urandom_range(0, 2))
			put_chunk(($urandom_range(0, 3) == 0) ? TAG_FMT : 32'($urandom));
		put32(TAG_DATA);
		n = $urandom_range(0, 24);
		put32(n);
		repeat (n) put8(8'($urandom));
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(0, wav_bytes.size() - 1);
			wav_bytes[n] = wav_bytes[n] ^ (8'd1 << $urandom_range(0, 7));
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic rs, input logic eo);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= rs;
		s_axis_tlast <= eo;
		do @(posedge clk); while (!s_axis_tready);
		tracker.parse_byte(b, rs, eo);
		@(negedge clk);
	endtask

	// Sends wav_bytes[0..last], end_of_stream on the last one sent.
	task automatic send_run(input bit busy, input int last, input bit rs0);
		int i;
		int gap;
		for (i = 0; i <= last; i++) begin
			send_byte(wav_bytes[i], rs0 && i == 0, i == last);
			gap = busy ? 0 : pick_gap();
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_rate(input logic [31:0] v);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.want_rate = v;
	endtask

	// Receiver: short and long stalls, calm stretches, one long hold-off.
	initial begin : sink
		int  hold = 0;
		int  calm = 0;
		bit  pressed = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!pressed && tracker.byte_count >= 30) begin
				pressed = 1;
				hold = 80;
			end
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				hold--;
			end else begin
				m_axis_tready <= 1'b1;
				if (calm > 0)
					calm--;
				else if ($urandom_range(0, 99) < 4)
					calm = $urandom_range(20, 60);
				else if ($urandom_range(0, 99) < 20)
					hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
						: $urandom_range(1, 3);
			end
		end
	end

	initial begin : watchdog
		int idle = 0;
		@(posedge arst_n);
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle = 0;
			else
				idle++;
		end
		$display("tb_wav_pcm_stream_parser_unit NOT OK");
		$finish;
	end

	initial begin : stimulus
		logic [31:0] rates[4];
		int          p;
		int          mark;
		int          last;
		rates = '{32'd0, 32'hFFFF_FFFF, 32'd8000, 32'd0};
		rates[3] = $urandom;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// bad RIFF tag, then a byte while the error holds
		wav_bytes = '{8'h00, 8'hFF, 8'h49, 8'h46, 8'h5A};
		send_run(1, 4, 1);
		// bad WAVE tag on the ending byte: the tag error wins over truncation
		wav_bytes.delete();
		put32(TAG_RIFF);
		put32(32'hFFFF_FFFF);
		put32(TAG_WAVE ^ 32'h8000_0000);
		send_run(1, 11, 1);
		// file ends inside the header
		wav_bytes.delete();
		put32(TAG_RIFF);
		send_run(1, 3, 1);

		for (p = 0; p <= 4; p++) begin
			if (p > 0) begin
				drain();
				write_rate(rates[p - 1]);
			end
			mark = tracker.byte_count;
			while (tracker.byte_count - mark < PHASE_BYTES) begin
				make_wav(tracker.want_rate);
				last = wav_bytes.size() - 1;
				if ($urandom_range(0, 7) == 0)
					last = $urandom_range(0, last);
				send_run($urandom_range(0, 3) == 0, last, $urandom_range(0, 9) != 0);
				if ($urandom_range(0, 5) == 0)
					repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'b0);
			end
		end

		drain();
		if (tracker.pending() != 0)
			tracker.report($sformatf("%0d results never arrived", tracker.pending()));
		if (tracker.error_count == 0)
			$display("tb_wav_pcm_stream_parser_unit OK");
		else
			$display("tb_wav_pcm_stream_parser_unit NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+src
src/wps_pkg.sv
src/wav_pcm_stream_parser_unit.sv
tb/tb_wav_pcm_stream_parser_unit.sv
